// ===== rtl/wave_equation_stencil_step_assert.svh =====
// Assertion macros shared by the stencil step RTL
`ifndef WAVE_EQUATION_STENCIL_STEP_ASSERT_SVH
`define WAVE_EQUATION_STENCIL_STEP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define WES_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wes: same-cycle check failed");

// next-cycle implication
`define WES_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wes: next-cycle check failed");

`endif

// ===== rtl/wes_pkg.sv =====
// Types and constants of the wave equation stencil step block
package wes_pkg;

	localparam int SB         = 16;  // sample and coefficient width
	localparam int IDX_W      = 6;
	localparam int NPTS_W     = 7;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// scaling of the exact accumulator (Q.41) back to Q4.12
	localparam int CF_SHIFT   = 15;
	localparam int OUT_SHIFT  = 29;
	localparam int ACC_W      = 3 * SB + 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [MODE_W-1:0] MODE_FIXED    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FREE     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OUTFLOW  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PERIODIC = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DRIVEN   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EQ_MODE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_COEFF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COEFF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS      = 3'd5;

	localparam logic [SB-1:0]     COEFF_RST  = 16'h8000;
	localparam logic [NPTS_W-1:0] POINTS_RST = 7'd64;
	localparam logic [NPTS_W-1:0] MIN_POINTS = 7'd3;

	localparam logic signed [SB-1:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [SB:0]   ONE_Q15 = 17'sd32768;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} st_t;

	// what a sweep read request does once its data is back
	typedef enum logic [2:0] {
		K_LAST,   // read f[N-1] for the left periodic end
		K_FIRST,  // read f[0]
		K_LEFT,   // read f[1], compute point 0
		K_MID,    // read f[j], compute interior point j-1
		K_RIGHT   // no read, compute point N-1
	} kind_t;

	typedef struct packed {
		logic  load;
		logic  start;
		logic  issue;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic adv;
		logic busy;
	} stat_t;

endpackage

// ===== rtl/wes_ifs.sv =====
// Request channels of the stencil step block
interface wes_in_if;
	import wes_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [IDX_W-1:0]     point_index;
	logic signed [SB-1:0] past_sample;
	logic signed [SB-1:0] present_sample;
	logic [SB-1:0]        courant_sq;
	logic signed [SB-1:0] slope_factor;
	logic signed [SB-1:0] drive_value;

	modport source (output valid, op, point_index, past_sample, present_sample,
		courant_sq, slope_factor, drive_value, input ready);
	modport sink (input valid, op, point_index, past_sample, present_sample,
		courant_sq, slope_factor, drive_value, output ready);
endinterface

interface wes_out_if;
	import wes_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [IDX_W-1:0]     out_index;
	logic signed [SB-1:0] new_sample;
	logic                 last;

	modport source (output valid, out_index, new_sample, last, input ready);
	modport sink (input valid, out_index, new_sample, last, output ready);
endinterface

// ===== rtl/wes_ctl.sv =====
// Controller: accepts requests and sequences the row sweep
`include "wave_equation_stencil_step_assert.svh"

module wes_ctl #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_op,
	input  logic [wes_pkg::IDX_W-1:0]           in_index,
	input  logic [wes_pkg::NPTS_W-1:0]          points_in_use,
	input  wes_pkg::stat_t                      st,
	output wes_pkg::cmd_t                       cmd,
	output logic [$clog2(MAX_POINTS)-1:0]       addr,
	output logic [$clog2(MAX_POINTS)-1:0]       last_idx
);
	import wes_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int QW = $clog2(MAX_POINTS + 2);

	st_t               state_q, state_d;
	logic [QW-1:0]     cnt_q;
	logic [QW-1:0]     n_q;
	logic [NPTS_W-1:0] n_clamp;
	logic              issue_done;
	logic              take;

	assign take       = in_valid && (state_q == ST_IDLE);
	assign issue_done = (cnt_q == n_q + QW'(1));
	assign last_idx   = AW'(n_q - QW'(1));

	always_comb begin
		n_clamp = points_in_use;
		if (points_in_use < MIN_POINTS) begin
			n_clamp = MIN_POINTS;
		end else if (points_in_use > NPTS_W'(MAX_POINTS)) begin
			n_clamp = NPTS_W'(MAX_POINTS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cnt_q <= '0;
				n_q   <= QW'(n_clamp);
			end else if (state_q == ST_ISSUE && st.adv) begin
				cnt_q <= cnt_q + QW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && in_op == OP_STEP) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (st.adv && issue_done) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!st.busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// read order: f[N-1], then f[0] .. f[N-1], then one flush slot for the right end
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		cmd.load  = take && in_op == OP_LOAD
			&& ({1'b0, in_index} < (IDX_W + 1)'(MAX_POINTS));
		cmd.start = take && in_op == OP_STEP;
		cmd.issue = (state_q == ST_ISSUE);
		addr      = (cnt_q == '0) ? last_idx : AW'(cnt_q - QW'(1));
		if (cnt_q == '0) begin
			cmd.kind = K_LAST;
		end else if (cnt_q == QW'(1)) begin
			cmd.kind = K_FIRST;
		end else if (cnt_q == QW'(2)) begin
			cmd.kind = K_LEFT;
		end else if (issue_done) begin
			cmd.kind = K_RIGHT;
		end else begin
			cmd.kind = K_MID;
		end
	end

	`WES_ASSERT_NXT(a_start_issue, cmd.start, state_q == ST_ISSUE && cnt_q == '0)
	`WES_ASSERT_NXT(a_stall_hold, state_q == ST_ISSUE && !st.adv, state_q == ST_ISSUE && $stable(cnt_q))
	`WES_ASSERT_IMP(a_idle_quiet, state_q == ST_IDLE, !st.busy)

endmodule

// ===== rtl/wes_dp.sv =====
// Datapath: row memories, stencil window, multiply pipeline, output register
module wes_dp #(
	parameter int MAX_POINTS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wes_pkg::cmd_t                    cmd,
	input  logic [$clog2(MAX_POINTS)-1:0]    addr,
	input  logic [$clog2(MAX_POINTS)-1:0]    last_idx,
	input  logic [$clog2(MAX_POINTS)-1:0]    ld_idx,
	input  logic signed [wes_pkg::SB-1:0]    ld_past,
	input  logic signed [wes_pkg::SB-1:0]    ld_present,
	input  logic [wes_pkg::SB-1:0]           ld_courant,
	input  logic signed [wes_pkg::SB-1:0]    ld_slope,
	input  logic signed [wes_pkg::SB-1:0]    drive_value,
	input  logic [wes_pkg::MODE_W-1:0]       left_mode,
	input  logic [wes_pkg::MODE_W-1:0]       right_mode,
	input  logic                             eq_mode,
	input  logic [wes_pkg::SB-1:0]           left_coeff,
	input  logic [wes_pkg::SB-1:0]           right_coeff,
	output wes_pkg::stat_t                   st,
	wes_out_if.source                        out_ch
);
	import wes_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	logic [SB-1:0] pres_mem  [MAX_POINTS];
	logic [SB-1:0] past_mem  [MAX_POINTS];
	logic [SB-1:0] cour_mem  [MAX_POINTS];
	logic [SB-1:0] slope_mem [MAX_POINTS];

	logic adv;

	// read stage
	logic                 vld_s1;
	kind_t                kind_s1;
	logic [AW-1:0]        addr_s1;
	logic signed [SB-1:0] rd_f_s1, rd_p_s1, rd_s_s1;
	logic [SB-1:0]        rd_b_s1;

	// stencil window
	logic signed [SB-1:0] f_prev_q, f_cur_q, f_last_q, f0_q, p_cur_q, s_cur_q, drive_q;
	logic [SB-1:0]        b_cur_q;

	// operand select
	logic                 is_point, edge_left;
	logic [MODE_W-1:0]    emode;
	logic signed [SB-1:0] fe, fi, fo;
	logic [SB-1:0]        coef;
	logic signed [SB:0]   opa, opb, opy;
	logic signed [SB-1:0] opx, ops, opp;
	logic [AW-1:0]        pt_idx;

	// multiply stages
	logic                    vld_s2, last_s2, vld_s3, last_s3;
	logic [AW-1:0]           idx_s2, idx_s3;
	logic signed [2*SB:0]    m1_s2, m1_s3;
	logic signed [2*SB+1:0]  m2_s2;
	logic signed [SB-1:0]    ops_s2, opp_s2, opp_s3;
	logic signed [3*SB+1:0]  m3_s3;

	// final sum, round, saturate
	logic signed [ACC_W-1:0] acc, accr, rnd;
	logic                    fits;
	logic signed [SB-1:0]    sample_d;

	// output register
	logic                 out_valid_q, out_last_q;
	logic [AW-1:0]        out_idx_q;
	logic signed [SB-1:0] out_sample_q;

	assign adv     = !out_valid_q || out_ch.ready;
	assign st.adv  = adv;
	assign st.busy = vld_s1 || vld_s2 || vld_s3;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_index  = IDX_W'(out_idx_q);
	assign out_ch.new_sample = out_sample_q;
	assign out_ch.last       = out_last_q;

	assign is_point = kind_s1 inside {K_LEFT, K_MID, K_RIGHT};
	assign pt_idx   = (kind_s1 == K_RIGHT) ? last_idx : addr_s1 - AW'(1);

	// memories: loads only while idle, so sweep writes never collide with them
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pres_mem[ld_idx] <= ld_present;
		end else if (adv && vld_s3) begin
			pres_mem[idx_s3] <= sample_d;
		end
		if (adv && cmd.issue && cmd.kind != K_RIGHT) begin
			rd_f_s1 <= $signed(pres_mem[addr]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			past_mem[ld_idx] <= ld_past;
		end else if (adv && vld_s1 && is_point) begin
			past_mem[pt_idx] <= f_cur_q;
		end
		if (adv && cmd.issue && cmd.kind != K_RIGHT) begin
			rd_p_s1 <= $signed(past_mem[addr]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cour_mem[ld_idx]  <= ld_courant;
			slope_mem[ld_idx] <= ld_slope;
		end
		if (adv && cmd.issue && cmd.kind != K_RIGHT) begin
			rd_b_s1 <= cour_mem[addr];
			rd_s_s1 <= $signed(slope_mem[addr]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= cmd.issue;
			vld_s2      <= vld_s1 && is_point;
			vld_s3      <= vld_s2;
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) drive_q <= drive_value;
		if (adv) begin
			kind_s1 <= cmd.kind;
			addr_s1 <= addr;
			if (vld_s1) begin
				case (kind_s1)
					K_LAST: f_last_q <= rd_f_s1;
					K_FIRST, K_LEFT, K_MID: begin
						if (kind_s1 == K_FIRST) f0_q <= rd_f_s1;
						f_prev_q <= f_cur_q;
						f_cur_q  <= rd_f_s1;
						p_cur_q  <= rd_p_s1;
						b_cur_q  <= rd_b_s1;
						s_cur_q  <= rd_s_s1;
					end
					default: ;
				endcase
			end
		end
	end

	// every point is round29(A*X*2^15 - P*2^29 + B*Y*S); ends use A = S = 1.0 in Q2.14
	always_comb begin
		edge_left = (kind_s1 == K_LEFT);
		emode     = edge_left ? left_mode : right_mode;
		fe        = f_cur_q;
		fi        = edge_left ? rd_f_s1 : f_prev_q;
		fo        = edge_left ? f_last_q : f0_q;
		coef      = edge_left ? left_coeff : right_coeff;
		opa       = (SB + 1)'(ONE_Q14);
		opx       = fe;
		opb       = '0;
		opy       = '0;
		ops       = ONE_Q14;
		opp       = '0;
		if (kind_s1 == K_MID) begin
			opa = ONE_Q15 - $signed({1'b0, b_cur_q});
			opb = $signed({1'b0, b_cur_q});
			opy = $signed({rd_f_s1[SB-1], rd_f_s1}) + $signed({f_prev_q[SB-1], f_prev_q});
			ops = eq_mode ? s_cur_q : ONE_Q14;
			opp = p_cur_q;
		end else begin
			case (emode)
				MODE_FREE:     opx = fi;
				MODE_OUTFLOW: begin
					opb = $signed({1'b0, coef});
					opy = $signed({fi[SB-1], fi}) - $signed({fe[SB-1], fe});
				end
				MODE_PERIODIC: opx = fo;
				MODE_DRIVEN:   opx = drive_q;
				default:       opx = fe;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s2   <= opa * opx;
			m2_s2   <= opb * opy;
			ops_s2  <= ops;
			opp_s2  <= opp;
			idx_s2  <= pt_idx;
			last_s2 <= (kind_s1 == K_RIGHT);

			m3_s3   <= m2_s2 * ops_s2;
			m1_s3   <= m1_s2;
			opp_s3  <= opp_s2;
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;

			out_sample_q <= sample_d;
			out_idx_q    <= idx_s3;
			out_last_q   <= last_s3;
		end
	end

	always_comb begin
		acc  = (ACC_W'(m1_s3) <<< CF_SHIFT) - (ACC_W'(opp_s3) <<< OUT_SHIFT) + ACC_W'(m3_s3);
		accr = acc + (ACC_W'(1) <<< (OUT_SHIFT - 1));
		rnd  = accr >>> OUT_SHIFT;
		fits = (&rnd[ACC_W-1:SB-1]) || !(|rnd[ACC_W-1:SB-1]);
		sample_d = fits ? rnd[SB-1:0] : {rnd[ACC_W-1], {(SB - 1){~rnd[ACC_W-1]}}};
	end

endmodule

// ===== rtl/wave_equation_stencil_step.sv =====
// Top level of the 1D wave equation stencil step block
// Load request: no result. Step request: N results (N = clamped points_in_use),
// one per cycle while the sink takes them, after the window fill and pipe stages.
// in_ready drops after a step until the sweep is issued and the pipe stages drain:
// one read port per row memory sweeps f[N-1], f[0..N-1], a flush slot, then 3 pipe stages.
// Reset clears control and restores register defaults; row memories are undefined until loaded.
module wave_equation_stencil_step #(
	parameter int MAX_POINTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wes_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wes_pkg::CFG_DATA_W-1:0]    cfg_data,
	wes_in_if.sink                            in_ch,
	wes_out_if.source                         out_ch
);
	import wes_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	logic [MODE_W-1:0] left_mode_q, right_mode_q;
	logic              eq_mode_q;
	logic [SB-1:0]     left_coeff_q, right_coeff_q;
	logic [NPTS_W-1:0] points_q;

	cmd_t          cmd;
	stat_t         st;
	logic [AW-1:0] addr, last_idx;
	logic          in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mode_q   <= MODE_FIXED;
			right_mode_q  <= MODE_FIXED;
			eq_mode_q     <= 1'b0;
			left_coeff_q  <= COEFF_RST;
			right_coeff_q <= COEFF_RST;
			points_q      <= POINTS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_MODE:   left_mode_q   <= cfg_data[MODE_W-1:0];
				REG_RIGHT_MODE:  right_mode_q  <= cfg_data[MODE_W-1:0];
				REG_EQ_MODE:     eq_mode_q     <= cfg_data[0];
				REG_LEFT_COEFF:  left_coeff_q  <= cfg_data[SB-1:0];
				REG_RIGHT_COEFF: right_coeff_q <= cfg_data[SB-1:0];
				REG_POINTS:      points_q      <= cfg_data[NPTS_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = in_ready;

	wes_ctl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ready),
		.in_op        (in_ch.op),
		.in_index     (in_ch.point_index),
		.points_in_use(points_q),
		.st           (st),
		.cmd          (cmd),
		.addr         (addr),
		.last_idx     (last_idx)
	);

	wes_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.addr       (addr),
		.last_idx   (last_idx),
		.ld_idx     (in_ch.point_index[AW-1:0]),
		.ld_past    (in_ch.past_sample),
		.ld_present (in_ch.present_sample),
		.ld_courant (in_ch.courant_sq),
		.ld_slope   (in_ch.slope_factor),
		.drive_value(in_ch.drive_value),
		.left_mode  (left_mode_q),
		.right_mode (right_mode_q),
		.eq_mode    (eq_mode_q),
		.left_coeff (left_coeff_q),
		.right_coeff(right_coeff_q),
		.st         (st),
		.out_ch     (out_ch)
	);

endmodule
